>>> sv/rswc_pkg.sv
// Shared types, codes and constants of the setter write census.
package rswc_pkg;

   localparam int FILL_W   = 7;
   localparam int CNT_W    = 32;
   localparam int SUM_W    = 40;
   localparam int SNAP_CNT = 14;

   localparam logic [2:0] MODE_CALL    = 3'd0;
   localparam logic [2:0] MODE_KEY_OVF = 3'd1;
   localparam logic [2:0] MODE_INVAL   = 3'd2;
   localparam logic [2:0] MODE_TEX     = 3'd3;
   localparam logic [2:0] MODE_FRAME   = 3'd4;
   localparam logic [2:0] MODE_SNAP    = 3'd5;
   localparam logic [2:0] MODE_READ    = 3'd6;
   localparam logic [2:0] MODE_UNUSED  = 3'd7;

   localparam logic [1:0] OC_APPLIED = 2'd0;
   localparam logic [1:0] OC_FAILED  = 2'd1;

   localparam logic [2:0] CLS_FIRST    = 3'd0;
   localparam logic [2:0] CLS_SAME     = 3'd1;
   localparam logic [2:0] CLS_CHANGED  = 3'd2;
   localparam logic [2:0] CLS_FAILED   = 3'd3;
   localparam logic [2:0] CLS_UNSUP    = 3'd4;
   localparam logic [2:0] CLS_SLOT_OVF = 3'd5;
   localparam logic [2:0] CLS_NOT_CALL = 3'd6;

   localparam logic [1:0] DS_SEEN  = 2'd0;
   localparam logic [1:0] DS_ADDED = 2'd1;
   localparam logic [1:0] DS_FULL  = 2'd2;
   localparam logic [1:0] DS_NONE  = 2'd3;

   localparam logic [3:0] CSEL_CALLS      = 4'd0;
   localparam logic [3:0] CSEL_FCALLS     = 4'd1;
   localparam logic [3:0] CSEL_FCHANGES   = 4'd2;
   localparam logic [3:0] CSEL_FIRSTS     = 4'd3;
   localparam logic [3:0] CSEL_SAMES      = 4'd4;
   localparam logic [3:0] CSEL_CHANGES    = 4'd5;
   localparam logic [3:0] CSEL_FAILS      = 4'd6;
   localparam logic [3:0] CSEL_UNSUP      = 4'd7;
   localparam logic [3:0] CSEL_KOVF       = 4'd8;
   localparam logic [3:0] CSEL_DOVF       = 4'd9;
   localparam logic [3:0] CSEL_FILL       = 4'd10;
   localparam logic [3:0] CSEL_VALID      = 4'd11;
   localparam logic [3:0] CSEL_RUN        = 4'd12;
   localparam logic [3:0] CSEL_MAXRUN     = 4'd13;
   localparam logic [3:0] CSEL_MAXFCALLS  = 4'd14;
   localparam logic [3:0] CSEL_MAXFCHANGE = 4'd15;

   localparam logic [3:0] SNAP_LAST = 4'd13;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] ordinal;
      logic [31:0] key;
      logic [1:0]  outcome;
      logic [3:0]  counter_select;
   } req_type;

   typedef struct packed {
      logic [2:0]       call_class;
      logic [1:0]       distinct_status;
      logic [3:0]       counter_id;
      logic [SUM_W-1:0] counter_value;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]  calls;
      logic [CNT_W-1:0]  fcalls;
      logic [CNT_W-1:0]  fchanges;
      logic [CNT_W-1:0]  firsts;
      logic [CNT_W-1:0]  sames;
      logic [CNT_W-1:0]  changes;
      logic [CNT_W-1:0]  fails;
      logic [CNT_W-1:0]  unsup;
      logic [CNT_W-1:0]  kovf;
      logic [CNT_W-1:0]  dovf;
      logic [CNT_W-1:0]  run;
      logic [CNT_W-1:0]  maxrun;
      logic [CNT_W-1:0]  maxfcalls;
      logic [CNT_W-1:0]  maxfchanges;
      logic [FILL_W-1:0] fill;
      logic              valid;
   } slot_rec_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_SLOT_WAIT, S_KEY_RD, S_KEY_CMP,
      S_CALL_WR, S_SW_RD, S_SW_WR, S_EMIT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_SLOT_RD, DP_KEY_RD, DP_CALL_WR, DP_KOVF_WR,
      DP_READ_OUT, DP_INV_WR, DP_FRAME_WR, DP_SNAP_CLR, DP_SNAP_ACC,
      DP_CLEAR_WR, DP_FIN_OVF, DP_FIN_INV, DP_FIN_TEX, DP_FIN_FRAME,
      DP_FIN_NONE, DP_EMIT_SNAP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       sweep;
      logic       hit;
      logic [3:0] snap_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic              ord_ok;
      logic [FILL_W-1:0] fill;
      logic              key_hit;
   } dp_status_type;

endpackage

>>> sv/redundant_state_write_census_unit.sv
// Top level of the setter write census: sequencer plus slot datapath.
//
//  channel  ports                    handshake
//  request  start, busy, req_data    taken when start is high and busy is low
//  result   rsp_valid, rsp_data      one cycle per result, cannot be held off
//
// One transaction at a time. A call's result waits on a scan of the stored keys
// of its slot, one key at a time through the one-port key store, that stops at
// the first match. Invalidate and frame end walk every slot, reading and writing
// back each record. Snapshot walks the slots, then gives 14 results back to
// back. After reset, a clearing pass over every slot holds busy high.
module redundant_state_write_census_unit #(
   parameter int SLOTS          = 64,
   parameter int DISTINCT_DEPTH = 8,
   parameter int KEY_WIDTH      = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rswc_pkg::req_type req_data,
   output logic              rsp_valid,
   output rswc_pkg::rsp_type rsp_data
);
   import rswc_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ST_W   = (SLOTS * DISTINCT_DEPTH > 1) ? $clog2(SLOTS * DISTINCT_DEPTH) : 1;

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [SLOT_W-1:0] idx;
   logic [FILL_W-1:0] kidx;

   rswc_ctrl #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd),
      .idx    (idx),
      .kidx   (kidx)
   );

   rswc_dp #(
      .SLOTS          (SLOTS),
      .DISTINCT_DEPTH (DISTINCT_DEPTH),
      .KEY_WIDTH      (KEY_WIDTH),
      .SLOT_W         (SLOT_W),
      .ST_W           (ST_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .idx       (idx),
      .kidx      (kidx),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/rswc_ctrl.sv
// Sequencer of the setter write census: decodes modes and steps sweeps and key scans.
module rswc_ctrl #(
   parameter int SLOTS  = 64,
   parameter int SLOT_W = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rswc_pkg::dp_status_type status,
   output rswc_pkg::dp_cmd_type    cmd,
   output logic [SLOT_W-1:0]      idx,
   output logic [rswc_pkg::FILL_W-1:0] kidx
);
   import rswc_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [FILL_W-1:0] j_ff, j_in;
   logic [3:0]        k_ff, k_in;
   logic              hit_ff, hit_in;
   logic              idx_last;

   assign idx_last = (idx_ff == SLOT_W'(SLOTS - 1));
   assign busy     = (state_ff != S_IDLE);
   assign idx      = idx_ff;
   assign kidx     = j_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         hit_ff   <= hit_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         S_CLEAR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_last) begin
               state_in = S_IDLE;
               idx_in   = '0;
            end
         end
         S_IDLE: if (start) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (status.mode)
               MODE_CALL, MODE_KEY_OVF, MODE_READ:
                  state_in = status.ord_ok ? S_SLOT_WAIT : S_IDLE;
               MODE_INVAL, MODE_FRAME, MODE_SNAP: begin
                  state_in = S_SW_RD;
                  idx_in   = '0;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SLOT_WAIT: begin
            hit_in = 1'b0;
            j_in   = '0;
            priority if (status.mode == MODE_CALL && status.fill != '0) state_in = S_KEY_RD;
            else if (status.mode == MODE_CALL) state_in = S_CALL_WR;
            else state_in = S_IDLE;
         end
         S_KEY_RD: state_in = S_KEY_CMP;
         S_KEY_CMP: begin
            priority if (status.key_hit) begin
               hit_in   = 1'b1;
               state_in = S_CALL_WR;
            end else if (FILL_W'(j_ff + 1'b1) == status.fill) begin
               state_in = S_CALL_WR;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_KEY_RD;
            end
         end
         S_CALL_WR: state_in = S_IDLE;
         S_SW_RD:   state_in = S_SW_WR;
         S_SW_WR: begin
            if (idx_last) begin
               state_in = S_EMIT;
               k_in     = '0;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SW_RD;
            end
         end
         S_EMIT: begin
            if (status.mode != MODE_SNAP || k_ff == SNAP_LAST) state_in = S_IDLE;
            else k_in = k_ff + 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = DP_NOP;
      cmd.sweep    = 1'b0;
      cmd.hit      = hit_ff;
      cmd.snap_idx = k_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op    = DP_CLEAR_WR;
            cmd.sweep = 1'b1;
         end
         S_IDLE: if (start) cmd.op = DP_LOAD;
         S_DISPATCH: begin
            unique case (status.mode)
               MODE_CALL, MODE_KEY_OVF: cmd.op = status.ord_ok ? DP_SLOT_RD : DP_FIN_OVF;
               MODE_READ:   cmd.op = status.ord_ok ? DP_SLOT_RD : DP_READ_OUT;
               MODE_SNAP:   cmd.op = DP_SNAP_CLR;
               MODE_TEX:    cmd.op = DP_FIN_TEX;
               MODE_UNUSED: cmd.op = DP_FIN_NONE;
               default:     cmd.op = DP_NOP;
            endcase
         end
         S_SLOT_WAIT: begin
            if (status.mode == MODE_KEY_OVF) cmd.op = DP_KOVF_WR;
            else if (status.mode == MODE_READ) cmd.op = DP_READ_OUT;
         end
         S_KEY_RD:  cmd.op = DP_KEY_RD;
         S_CALL_WR: cmd.op = DP_CALL_WR;
         S_SW_RD: begin
            cmd.op    = DP_SLOT_RD;
            cmd.sweep = 1'b1;
         end
         S_SW_WR: begin
            cmd.sweep = 1'b1;
            if (status.mode == MODE_INVAL) cmd.op = DP_INV_WR;
            else if (status.mode == MODE_FRAME) cmd.op = DP_FRAME_WR;
            else cmd.op = DP_SNAP_ACC;
         end
         S_EMIT: begin
            if (status.mode == MODE_SNAP) cmd.op = DP_EMIT_SNAP;
            else if (status.mode == MODE_INVAL) cmd.op = DP_FIN_INV;
            else cmd.op = DP_FIN_FRAME;
         end
         default: cmd.op = DP_NOP;
      endcase
   end

   a_scan_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KEY_CMP) |-> (j_ff < status.fill))
      else $error("key scan ran past the fill count");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> (state_ff == S_DISPATCH))
      else $error("accepted transaction not dispatched");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (k_ff <= SNAP_LAST))
      else $error("snapshot index out of range");

endmodule

>>> sv/rswc_dp.sv
// Datapath of the setter write census: slot tables, key stores, globals and result register.
module rswc_dp #(
   parameter int SLOTS          = 64,
   parameter int DISTINCT_DEPTH = 8,
   parameter int KEY_WIDTH      = 32,
   parameter int SLOT_W         = 6,
   parameter int ST_W           = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rswc_pkg::req_type           req_data,
   input  rswc_pkg::dp_cmd_type        cmd,
   input  logic [SLOT_W-1:0]           idx,
   input  logic [rswc_pkg::FILL_W-1:0] kidx,
   output rswc_pkg::dp_status_type     status,
   output logic                        rsp_valid,
   output rswc_pkg::rsp_type           rsp_data
);
   import rswc_pkg::*;

   localparam int STORE_DEPTH = SLOTS * DISTINCT_DEPTH;

   slot_rec_type         slot_mem [SLOTS];
   logic [KEY_WIDTH-1:0] akey_mem [SLOTS];
   logic [KEY_WIDTH-1:0] store_mem [STORE_DEPTH];

   req_type              req_ff;
   slot_rec_type         slot_q;
   logic [KEY_WIDTH-1:0] akey_q, store_q, key_eff;
   logic [SUM_W-1:0]     acc_ff [9];
   logic                 seen_ff;
   logic [CNT_W-1:0]     sovf_ff, inval_ff, frame_ff, tex_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [SLOT_W-1:0]    slot_addr;
   logic [ST_W-1:0]      st_base, st_rd_addr, st_wr_addr;
   logic                 ord_ok;
   slot_rec_type         rec_in;
   logic                 slot_we, store_we, akey_we;
   logic [2:0]           cls;
   logic [1:0]           ds;
   logic [CNT_W-1:0]     sel_val;
   logic [SUM_W-1:0]     snap_val;
   logic                 active;

   assign key_eff    = KEY_WIDTH'(req_ff.key);
   assign ord_ok     = ({1'b0, req_ff.ordinal} < 17'(SLOTS));
   assign slot_addr  = cmd.sweep ? idx : req_ff.ordinal[SLOT_W-1:0];
   assign st_base    = ST_W'(req_ff.ordinal[SLOT_W-1:0]) * ST_W'(DISTINCT_DEPTH);
   assign st_rd_addr = st_base + ST_W'(kidx);
   assign st_wr_addr = st_base + ST_W'(slot_q.fill);
   assign active     = (slot_q.calls != '0) || (slot_q.kovf != '0);

   assign status.mode    = req_ff.mode;
   assign status.ord_ok  = ord_ok;
   assign status.fill    = slot_q.fill;
   assign status.key_hit = (store_q == key_eff);

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) req_ff <= req_data;
      if (cmd.op == DP_SLOT_RD) begin
         slot_q <= slot_mem[slot_addr];
         akey_q <= akey_mem[slot_addr];
      end
      if (cmd.op == DP_KEY_RD) store_q <= store_mem[st_rd_addr];
      if (slot_we) slot_mem[slot_addr] <= rec_in;
      if (akey_we) akey_mem[slot_addr] <= key_eff;
      if (store_we) store_mem[st_wr_addr] <= key_eff;
   end

   // Slot record update for the write-back commands.
   always_comb begin
      rec_in   = slot_q;
      slot_we  = 1'b0;
      store_we = 1'b0;
      akey_we  = 1'b0;
      cls      = CLS_NOT_CALL;
      ds       = DS_NONE;
      unique case (cmd.op)
         DP_CALL_WR: begin
            slot_we        = 1'b1;
            rec_in.calls   = slot_q.calls + 1'b1;
            rec_in.fcalls  = slot_q.fcalls + 1'b1;
            priority if (cmd.hit) begin
               ds = DS_SEEN;
            end else if (slot_q.fill >= FILL_W'(DISTINCT_DEPTH)) begin
               ds          = DS_FULL;
               rec_in.dovf = slot_q.dovf + 1'b1;
            end else begin
               ds          = DS_ADDED;
               store_we    = 1'b1;
               rec_in.fill = slot_q.fill + 1'b1;
            end
            priority if (req_ff.outcome == OC_FAILED) begin
               rec_in.fails = slot_q.fails + 1'b1;
               rec_in.valid = 1'b0;
               rec_in.run   = '0;
               cls          = CLS_FAILED;
            end else if (req_ff.outcome != OC_APPLIED) begin
               rec_in.unsup = slot_q.unsup + 1'b1;
               rec_in.valid = 1'b0;
               rec_in.run   = '0;
               cls          = CLS_UNSUP;
            end else if (!slot_q.valid) begin
               rec_in.firsts   = slot_q.firsts + 1'b1;
               rec_in.fchanges = slot_q.fchanges + 1'b1;
               rec_in.run      = '0;
               rec_in.valid    = 1'b1;
               akey_we         = 1'b1;
               cls             = CLS_FIRST;
            end else if (akey_q == key_eff) begin
               rec_in.sames = slot_q.sames + 1'b1;
               rec_in.run   = slot_q.run + 1'b1;
               if (rec_in.run > slot_q.maxrun) rec_in.maxrun = rec_in.run;
               cls = CLS_SAME;
            end else begin
               rec_in.changes  = slot_q.changes + 1'b1;
               rec_in.fchanges = slot_q.fchanges + 1'b1;
               rec_in.run      = '0;
               akey_we         = 1'b1;
               cls             = CLS_CHANGED;
            end
         end
         DP_KOVF_WR: begin
            slot_we     = 1'b1;
            rec_in.kovf = slot_q.kovf + 1'b1;
         end
         DP_INV_WR: begin
            slot_we      = 1'b1;
            rec_in.valid = 1'b0;
            rec_in.run   = '0;
         end
         DP_FRAME_WR: begin
            slot_we = 1'b1;
            if (slot_q.fcalls > slot_q.maxfcalls) rec_in.maxfcalls = slot_q.fcalls;
            if (slot_q.fchanges > slot_q.maxfchanges) rec_in.maxfchanges = slot_q.fchanges;
            rec_in.fcalls   = '0;
            rec_in.fchanges = '0;
         end
         DP_CLEAR_WR: begin
            slot_we = 1'b1;
            rec_in  = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (req_ff.counter_select)
         CSEL_CALLS:      sel_val = slot_q.calls;
         CSEL_FCALLS:     sel_val = slot_q.fcalls;
         CSEL_FCHANGES:   sel_val = slot_q.fchanges;
         CSEL_FIRSTS:     sel_val = slot_q.firsts;
         CSEL_SAMES:      sel_val = slot_q.sames;
         CSEL_CHANGES:    sel_val = slot_q.changes;
         CSEL_FAILS:      sel_val = slot_q.fails;
         CSEL_UNSUP:      sel_val = slot_q.unsup;
         CSEL_KOVF:       sel_val = slot_q.kovf;
         CSEL_DOVF:       sel_val = slot_q.dovf;
         CSEL_FILL:       sel_val = CNT_W'(slot_q.fill);
         CSEL_VALID:      sel_val = CNT_W'(slot_q.valid);
         CSEL_RUN:        sel_val = slot_q.run;
         CSEL_MAXRUN:     sel_val = slot_q.maxrun;
         CSEL_MAXFCALLS:  sel_val = slot_q.maxfcalls;
         CSEL_MAXFCHANGE: sel_val = slot_q.maxfchanges;
         default:         sel_val = '0;
      endcase
   end

   always_comb begin
      priority if (cmd.snap_idx == 4'd0) snap_val = SUM_W'(seen_ff);
      else if (cmd.snap_idx == 4'd1) snap_val = SUM_W'(sovf_ff);
      else if (cmd.snap_idx == 4'd2) snap_val = SUM_W'(inval_ff);
      else if (cmd.snap_idx == 4'd3) snap_val = SUM_W'(frame_ff);
      else if (cmd.snap_idx == 4'd4) snap_val = SUM_W'(tex_ff);
      else if (cmd.snap_idx <= SNAP_LAST) snap_val = acc_ff[cmd.snap_idx - 4'd5];
      else snap_val = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_SNAP_CLR) begin
         for (int i = 0; i < 9; i++) acc_ff[i] <= '0;
      end else if (cmd.op == DP_SNAP_ACC && active) begin
         acc_ff[0] <= acc_ff[0] + 1'b1;
         acc_ff[1] <= acc_ff[1] + SUM_W'(slot_q.calls);
         acc_ff[2] <= acc_ff[2] + SUM_W'(slot_q.firsts);
         acc_ff[3] <= acc_ff[3] + SUM_W'(slot_q.sames);
         acc_ff[4] <= acc_ff[4] + SUM_W'(slot_q.changes);
         acc_ff[5] <= acc_ff[5] + SUM_W'(slot_q.fails);
         acc_ff[6] <= acc_ff[6] + SUM_W'(slot_q.unsup);
         acc_ff[7] <= acc_ff[7] + SUM_W'(slot_q.kovf);
         acc_ff[8] <= acc_ff[8] + SUM_W'(slot_q.dovf);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         sovf_ff  <= '0;
         inval_ff <= '0;
         frame_ff <= '0;
         tex_ff   <= '0;
      end else begin
         if (cmd.op == DP_CALL_WR || cmd.op == DP_KOVF_WR || cmd.op == DP_FIN_OVF ||
             cmd.op == DP_FIN_INV || cmd.op == DP_FIN_TEX || cmd.op == DP_FIN_FRAME)
            seen_ff <= 1'b1;
         if (cmd.op == DP_FIN_OVF) sovf_ff <= sovf_ff + 1'b1;
         if (cmd.op == DP_FIN_INV) inval_ff <= inval_ff + 1'b1;
         if (cmd.op == DP_FIN_FRAME) frame_ff <= frame_ff + 1'b1;
         if (cmd.op == DP_FIN_TEX) tex_ff <= tex_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in           = 1'b1;
      rsp_in.call_class      = CLS_NOT_CALL;
      rsp_in.distinct_status = DS_NONE;
      rsp_in.counter_id      = '0;
      rsp_in.counter_value   = '0;
      rsp_in.last            = 1'b1;
      unique case (cmd.op)
         DP_CALL_WR: begin
            rsp_in.call_class      = cls;
            rsp_in.distinct_status = ds;
         end
         DP_FIN_OVF: rsp_in.call_class = CLS_SLOT_OVF;
         DP_READ_OUT: begin
            rsp_in.counter_id = req_ff.counter_select;
            if (ord_ok) rsp_in.counter_value = SUM_W'(sel_val);
            else rsp_in.call_class = CLS_SLOT_OVF;
         end
         DP_EMIT_SNAP: begin
            rsp_in.counter_id    = cmd.snap_idx;
            rsp_in.counter_value = snap_val;
            rsp_in.last          = (cmd.snap_idx == SNAP_LAST);
         end
         DP_KOVF_WR, DP_FIN_INV, DP_FIN_TEX, DP_FIN_FRAME, DP_FIN_NONE: ;
         default: rsp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (rsp_valid_in) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the setter write census unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rswc_pkg::*;

   localparam int NSLOT = 64;
   localparam int DDEPTH = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   redundant_state_write_census_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // census mirror
   logic [31:0] m_calls[NSLOT], m_fcalls[NSLOT], m_fchg[NSLOT], m_first[NSLOT];
   logic [31:0] m_same[NSLOT], m_chg[NSLOT], m_fail[NSLOT], m_unsup[NSLOT];
   logic [31:0] m_kovf[NSLOT], m_dovf[NSLOT], m_run[NSLOT], m_maxrun[NSLOT];
   logic [31:0] m_maxfc[NSLOT], m_maxfchg[NSLOT], m_fill[NSLOT];
   logic        m_valid[NSLOT];
   logic [31:0] m_applied[NSLOT];
   logic [31:0] m_keys[NSLOT][DDEPTH];
   logic [31:0] m_seen, m_slot_ovf, m_inval, m_frames, m_texgen;

   rsp_type     expected_rsp[$];
   int          fail_count = 0;
   int          idle_pct = 0;
   logic [31:0] key_pool[12];

   function automatic rsp_type mk_rsp(logic [2:0] cls, logic [1:0] ds, logic [3:0] id,
                                      logic [39:0] val, logic lst);
      rsp_type r;
      r.call_class = cls; r.distinct_status = ds; r.counter_id = id;
      r.counter_value = val; r.last = lst;
      return r;
   endfunction

   task automatic census_clear();
      for (int i = 0; i < NSLOT; i++) begin
         m_calls[i] = 0; m_fcalls[i] = 0; m_fchg[i] = 0; m_first[i] = 0;
         m_same[i] = 0; m_chg[i] = 0; m_fail[i] = 0; m_unsup[i] = 0;
         m_kovf[i] = 0; m_dovf[i] = 0; m_run[i] = 0; m_maxrun[i] = 0;
         m_maxfc[i] = 0; m_maxfchg[i] = 0; m_fill[i] = 0; m_valid[i] = 0;
         m_applied[i] = 0;
      end
      m_seen = 0; m_slot_ovf = 0; m_inval = 0; m_frames = 0; m_texgen = 0;
   endtask

   function automatic logic [31:0] slot_counter(int s, logic [3:0] sel);
      case (sel)
         CSEL_CALLS:      return m_calls[s];
         CSEL_FCALLS:     return m_fcalls[s];
         CSEL_FCHANGES:   return m_fchg[s];
         CSEL_FIRSTS:     return m_first[s];
         CSEL_SAMES:      return m_same[s];
         CSEL_CHANGES:    return m_chg[s];
         CSEL_FAILS:      return m_fail[s];
         CSEL_UNSUP:      return m_unsup[s];
         CSEL_KOVF:       return m_kovf[s];
         CSEL_DOVF:       return m_dovf[s];
         CSEL_FILL:       return m_fill[s];
         CSEL_VALID:      return {31'd0, m_valid[s]};
         CSEL_RUN:        return m_run[s];
         CSEL_MAXRUN:     return m_maxrun[s];
         CSEL_MAXFCALLS:  return m_maxfc[s];
         default:         return m_maxfchg[s];
      endcase
   endfunction

   // Update the mirror for one accepted transaction and queue its results.
   task automatic census_predict(req_type rq);
      int          s;
      logic [1:0]  ds;
      logic [2:0]  cls;
      logic        hit;
      logic [39:0] sums[SNAP_CNT];
      s = rq.ordinal;
      case (rq.mode)
         MODE_CALL, MODE_KEY_OVF: begin
            m_seen = 1;
            if (rq.ordinal >= NSLOT) begin
               m_slot_ovf++;
               expected_rsp.push_back(mk_rsp(CLS_SLOT_OVF, DS_NONE, 0, 0, 1'b1));
            end else if (rq.mode == MODE_KEY_OVF) begin
               m_kovf[s]++;
               expected_rsp.push_back(mk_rsp(CLS_NOT_CALL, DS_NONE, 0, 0, 1'b1));
            end else begin
               m_calls[s]++; m_fcalls[s]++;
               hit = 1'b0;
               for (int i = 0; i < DDEPTH; i++)
                  if (i < m_fill[s] && m_keys[s][i] == rq.key) hit = 1'b1;
               if (hit) ds = DS_SEEN;
               else if (m_fill[s] >= DDEPTH) begin
                  m_dovf[s]++; ds = DS_FULL;
               end else begin
                  m_keys[s][m_fill[s]] = rq.key; m_fill[s]++; ds = DS_ADDED;
               end
               if (rq.outcome == OC_FAILED) begin
                  m_fail[s]++; m_valid[s] = 0; m_run[s] = 0; cls = CLS_FAILED;
               end else if (rq.outcome != OC_APPLIED) begin
                  m_unsup[s]++; m_valid[s] = 0; m_run[s] = 0; cls = CLS_UNSUP;
               end else if (!m_valid[s]) begin
                  m_first[s]++; m_fchg[s]++; m_run[s] = 0;
                  m_applied[s] = rq.key; m_valid[s] = 1; cls = CLS_FIRST;
               end else if (m_applied[s] == rq.key) begin
                  m_same[s]++; m_run[s]++;
                  if (m_run[s] > m_maxrun[s]) m_maxrun[s] = m_run[s];
                  cls = CLS_SAME;
               end else begin
                  m_chg[s]++; m_fchg[s]++; m_run[s] = 0;
                  m_applied[s] = rq.key; cls = CLS_CHANGED;
               end
               expected_rsp.push_back(mk_rsp(cls, ds, 0, 0, 1'b1));
            end
         end
         MODE_SNAP: begin
            sums[0] = m_seen; sums[1] = m_slot_ovf; sums[2] = m_inval;
            sums[3] = m_frames; sums[4] = m_texgen;
            for (int k = 5; k < SNAP_CNT; k++) sums[k] = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (m_calls[i] != 0 || m_kovf[i] != 0) begin
                  sums[5] += 1;          sums[6] += m_calls[i];
                  sums[7] += m_first[i]; sums[8] += m_same[i];
                  sums[9] += m_chg[i];   sums[10] += m_fail[i];
                  sums[11] += m_unsup[i]; sums[12] += m_kovf[i];
                  sums[13] += m_dovf[i];
               end
            end
            for (int k = 0; k < SNAP_CNT; k++)
               expected_rsp.push_back(mk_rsp(CLS_NOT_CALL, DS_NONE, k, sums[k],
                                             k == SNAP_CNT - 1));
         end
         MODE_READ: begin
            if (rq.ordinal >= NSLOT)
               expected_rsp.push_back(mk_rsp(CLS_SLOT_OVF, DS_NONE,
                                             rq.counter_select, 0, 1'b1));
            else
               expected_rsp.push_back(mk_rsp(CLS_NOT_CALL, DS_NONE, rq.counter_select,
                                             slot_counter(s, rq.counter_select), 1'b1));
         end
         default: begin
            if (rq.mode == MODE_INVAL) begin
               m_seen = 1; m_inval++;
               for (int i = 0; i < NSLOT; i++) begin
                  m_valid[i] = 0; m_run[i] = 0;
               end
            end else if (rq.mode == MODE_TEX) begin
               m_seen = 1; m_texgen++;
            end else if (rq.mode == MODE_FRAME) begin
               m_seen = 1; m_frames++;
               for (int i = 0; i < NSLOT; i++) begin
                  if (m_fcalls[i] > m_maxfc[i]) m_maxfc[i] = m_fcalls[i];
                  if (m_fchg[i] > m_maxfchg[i]) m_maxfchg[i] = m_fchg[i];
                  m_fcalls[i] = 0; m_fchg[i] = 0;
               end
            end
            expected_rsp.push_back(mk_rsp(CLS_NOT_CALL, DS_NONE, 0, 0, 1'b1));
         end
      endcase
   endtask

   // Present one transaction, hold it until accepted, then maybe go idle.
   task automatic send_req(logic [2:0] mode, logic [15:0] ord, logic [31:0] key,
                           logic [1:0] oc, logic [3:0] sel);
      req_type rq;
      rq.mode = mode; rq.ordinal = ord; rq.key = key;
      rq.outcome = oc; rq.counter_select = sel;
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      census_predict(rq);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            fail_count++;
         end else begin
            exp_r = expected_rsp.pop_front();
            if (rsp_data.call_class !== exp_r.call_class) begin
               $error("call_class exp %0d got %0d", exp_r.call_class, rsp_data.call_class);
               fail_count++;
            end
            if (rsp_data.distinct_status !== exp_r.distinct_status) begin
               $error("distinct_status exp %0d got %0d", exp_r.distinct_status,
                      rsp_data.distinct_status);
               fail_count++;
            end
            if (rsp_data.counter_id !== exp_r.counter_id) begin
               $error("counter_id exp %0d got %0d", exp_r.counter_id, rsp_data.counter_id);
               fail_count++;
            end
            if (rsp_data.counter_value !== exp_r.counter_value) begin
               $error("counter_value exp %0h got %0h", exp_r.counter_value,
                      rsp_data.counter_value);
               fail_count++;
            end
            if (rsp_data.last !== exp_r.last) begin
               $error("last exp %0d got %0d", exp_r.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   task automatic test_directed();
      idle_pct = 0;
      send_req(MODE_CALL, 0, 32'h0, OC_APPLIED, 0);             // first
      send_req(MODE_CALL, 0, 32'h0, OC_APPLIED, 0);             // same
      send_req(MODE_CALL, 0, 32'hFFFF_FFFF, OC_APPLIED, 0);     // changed
      send_req(MODE_CALL, 0, 32'hFFFF_FFFF, OC_FAILED, 0);
      send_req(MODE_CALL, 0, 32'h1234_5678, 2'd2, 0);           // unsupported
      send_req(MODE_CALL, 0, 32'h1234_5678, 2'd3, 0);           // code three
      send_req(MODE_CALL, 16'd64, 32'h5, OC_APPLIED, 0);        // beyond table
      send_req(MODE_CALL, 16'hFFFF, 32'h5, OC_APPLIED, 0);
      send_req(MODE_KEY_OVF, 16'd63, 0, 0, 0);
      send_req(MODE_KEY_OVF, 16'hFFFF, 0, 0, 0);
      // fill the distinct set of slot 63 past its depth
      for (int i = 0; i < DDEPTH + 1; i++)
         send_req(MODE_CALL, 16'd63, 32'hA000_0000 + i, OC_APPLIED, 0);
      send_req(MODE_INVAL, 0, 0, 0, 0);
      send_req(MODE_TEX, 0, 0, 0, 0);
      send_req(MODE_FRAME, 0, 0, 0, 0);
      send_req(MODE_READ, 16'd63, 0, 0, CSEL_MAXFCALLS);
      send_req(MODE_READ, 16'hFFFF, 0, 0, 4'hF);
      send_req(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, 4'hF);
      send_req(MODE_SNAP, 0, 0, 0, 0);
   endtask

   task automatic test_random(int n, int pct);
      int          r;
      logic [2:0]  mode;
      logic [15:0] ord;
      logic [31:0] key;
      idle_pct = pct;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 60) mode = MODE_CALL;
         else if (r < 68) mode = MODE_KEY_OVF;
         else if (r < 71) mode = MODE_INVAL;
         else if (r < 75) mode = MODE_TEX;
         else if (r < 79) mode = MODE_FRAME;
         else if (r < 84) mode = MODE_SNAP;
         else if (r < 97) mode = MODE_READ;
         else mode = MODE_UNUSED;
         r = $urandom_range(99);
         if (r < 70) ord = $urandom_range(0, 5);
         else if (r < 93) ord = $urandom_range(0, NSLOT - 1);
         else ord = $urandom;
         key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(0, 11)] : $urandom;
         send_req(mode, ord, key, ($urandom_range(99) < 75) ? 2'd0 : $urandom_range(1, 3),
                  $urandom_range(0, 15));
      end
      // drain before the next phase
      if (start) start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      census_clear();
      for (int i = 0; i < 12; i++) key_pool[i] = (i < 4) ? i : $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(100, 0);
      test_random(95, 82);
      test_random(95, 29);
      test_random(90, 0);
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("[redundant_state_write_census_unit] OK");
      end else begin
         $display("[redundant_state_write_census_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("[redundant_state_write_census_unit] ERROR");
      $finish;
   end
endmodule
